FILE: design/vmpa_pkg.sv
// vmpa_pkg: shared constants, the arctangent table and the flag struct for
// the vector length and plane angle core; depends on nothing
package vmpa_pkg;

    localparam int COMPONENT_BITS_DEF  = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int DP_BITS             = 64;
    localparam int ACC_BITS            = 26;
    localparam int ACC_FRAC_BITS       = 16;
    localparam int ATAN_STEPS          = 21;
    localparam int DEG90_ACC           = 90 << ACC_FRAC_BITS;

    // flags that ride along with the rotation
    typedef struct packed {
        logic zero;   // second component is zero
        logic neg;    // first component is negative
    } t_ang_flag;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ACC_BITS-1:0] atan_step(input int idx);
        logic signed [ACC_BITS-1:0] v;
        case (idx)
            0:  v = ACC_BITS'(2949120);
            1:  v = ACC_BITS'(1740967);
            2:  v = ACC_BITS'(919879);
            3:  v = ACC_BITS'(466945);
            4:  v = ACC_BITS'(234379);
            5:  v = ACC_BITS'(117304);
            6:  v = ACC_BITS'(58666);
            7:  v = ACC_BITS'(29335);
            8:  v = ACC_BITS'(14668);
            9:  v = ACC_BITS'(7334);
            10: v = ACC_BITS'(3667);
            11: v = ACC_BITS'(1833);
            12: v = ACC_BITS'(917);
            13: v = ACC_BITS'(458);
            14: v = ACC_BITS'(229);
            15: v = ACC_BITS'(115);
            16: v = ACC_BITS'(57);
            17: v = ACC_BITS'(29);
            18: v = ACC_BITS'(14);
            19: v = ACC_BITS'(7);
            20: v = ACC_BITS'(4);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/vmpa_in_if.sv
// vmpa_in_if: input channel carrying one vector per item
// depends on nothing
interface vmpa_in_if #(
    parameter int CB = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] comp_x;
    logic signed [CB-1:0] comp_y;
    logic signed [CB-1:0] comp_z;

    modport source (output valid, comp_x, comp_y, comp_z, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

FILE: design/vmpa_out_if.sv
// vmpa_out_if: output channel carrying length and two angles per item
// depends on nothing
interface vmpa_out_if #(
    parameter int CB = 16,
    parameter int AW = 15
);
    logic                 valid;
    logic                 ready;
    logic        [CB-1:0] length;
    logic signed [AW-1:0] angle_xy;
    logic signed [AW-1:0] angle_xz;

    modport source (output valid, length, angle_xy, angle_xz, input ready);
    modport sink   (input valid, length, angle_xy, angle_xz, output ready);
endinterface

FILE: design/vector_magnitude_and_plane_angles_core.sv
// vector_magnitude_and_plane_angles_core: length by a chain of root-digit
// cells, two angles by chains of cordic cells; uses vmpa_pkg, both interfaces
//
//  channel | dir | fields                          | handshake
//  i_in    | in  | comp_x, comp_y, comp_z          | valid/ready
//  o_out   | out | length, angle_xy, angle_xz      | valid/ready
//
// one item enters per cycle while the output is not stalled; the depth of the
// chain is set by the 21 cordic cells plus prerotation and rounding, or by
// the COMPONENT_BITS+1 root-digit cells plus squaring and summing
// reset clears only the valid chain
// a stalled output freezes the whole chain; input ready follows it
module vector_magnitude_and_plane_angles_core
    import vmpa_pkg::*;
#(
    parameter int COMPONENT_BITS  = COMPONENT_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vmpa_in_if.sink    i_in,
    vmpa_out_if.source o_out
);
    localparam int CB     = COMPONENT_BITS;
    localparam int AW     = ANGLE_FRAC_BITS + 9;
    localparam int SHIFT  = 58 - CB;
    localparam int SW     = 2 * CB + 2;
    localparam int PW     = CB + 1;
    localparam int D_SQ   = PW + 2;
    localparam int D_AN   = ATAN_STEPS + 2;
    localparam int D      = (D_SQ > D_AN) ? D_SQ : D_AN;
    localparam int PAD_SQ = D - D_SQ;
    localparam int PAD_AN = D - D_AN;
    localparam int RSH    = ACC_FRAC_BITS - ANGLE_FRAC_BITS;
    localparam int HALF   = 1 << (RSH - 1);
    localparam int LIM    = 180 << ANGLE_FRAC_BITS;

    logic         w_en;
    logic [D-1:0] r_vld;

    // chain advances when the output slot is free or being taken
    assign w_en       = !r_vld[D-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[D-2:0], i_in.valid};
        end
    end

    // length lane: squares, sum, root digits
    logic [CB-1:0]   w_ax, w_ay, w_az;
    logic [2*CB-1:0] r_sqx, r_sqy, r_sqz;
    logic [SW-1:0]   r_sum;
    logic [SW-1:0]   w_n    [0:PW];
    logic [SW+1:0]   w_rem  [0:PW];
    logic [PW-1:0]   w_root [0:PW];

    assign w_ax = i_in.comp_x[CB-1] ? (~i_in.comp_x + 1'b1) : i_in.comp_x;
    assign w_ay = i_in.comp_y[CB-1] ? (~i_in.comp_y + 1'b1) : i_in.comp_y;
    assign w_az = i_in.comp_z[CB-1] ? (~i_in.comp_z + 1'b1) : i_in.comp_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx <= w_ax * w_ax;
            r_sqy <= w_ay * w_ay;
            r_sqz <= w_az * w_az;
            r_sum <= SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz);
        end
    end

    assign w_n[0]    = r_sum;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < PW; k++) begin : g_sqrt
        vmpa_sqrt_cell #(.SW(SW), .PW(PW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_n    (w_n[k]),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .o_n    (w_n[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1])
        );
    end

    logic [CB-1:0] w_len;
    if (PAD_SQ > 0) begin : g_pad_sq
        logic [CB-1:0] r_dly [0:PAD_SQ-1];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dly[0] <= w_root[PW][CB-1:0];
                for (int j = 1; j < PAD_SQ; j++) r_dly[j] <= r_dly[j-1];
            end
        end
        assign w_len = r_dly[PAD_SQ-1];
    end else begin : g_nopad_sq
        assign w_len = w_root[PW][CB-1:0];
    end

    // angle lanes: prerotation, cordic cells, rounding
    logic signed [AW-1:0] w_ang [0:1];

    for (genvar p = 0; p < 2; p++) begin : g_plane
        logic signed [CB-1:0]       w_den, w_num;
        logic signed [DP_BITS-1:0]  w_sx, w_sy, n_x0, n_y0;
        logic signed [ACC_BITS-1:0] n_acc0;
        t_ang_flag                  n_flag0;
        logic signed [DP_BITS-1:0]  w_x   [0:ATAN_STEPS];
        logic signed [DP_BITS-1:0]  w_y   [0:ATAN_STEPS];
        logic signed [ACC_BITS-1:0] w_acc [0:ATAN_STEPS];
        t_ang_flag                  w_flg [0:ATAN_STEPS];
        logic signed [DP_BITS-1:0]  r_x0, r_y0;
        logic signed [ACC_BITS-1:0] r_acc0, w_accr, w_rnd;
        t_ang_flag                  r_flag0;
        logic signed [AW-1:0]       r_ang, n_ang;

        assign w_den = i_in.comp_x;
        assign w_num = (p == 0) ? i_in.comp_y : i_in.comp_z;
        assign w_sx  = DP_BITS'(w_den) <<< SHIFT;
        assign w_sy  = DP_BITS'(w_num) <<< SHIFT;

        // fold the left half plane onto the right one
        always_comb begin
            n_flag0.zero = (w_num == '0);
            n_flag0.neg  = w_den[CB-1];
            if (!w_den[CB-1]) begin
                n_x0   = w_sx;
                n_y0   = w_sy;
                n_acc0 = '0;
            end else if (!w_num[CB-1] && (w_num != '0)) begin
                n_x0   = w_sy;
                n_y0   = -w_sx;
                n_acc0 = ACC_BITS'(DEG90_ACC);
            end else begin
                n_x0   = -w_sy;
                n_y0   = w_sx;
                n_acc0 = -ACC_BITS'(DEG90_ACC);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x0    <= n_x0;
                r_y0    <= n_y0;
                r_acc0  <= n_acc0;
                r_flag0 <= n_flag0;
            end
        end

        assign w_x[0]   = r_x0;
        assign w_y[0]   = r_y0;
        assign w_acc[0] = r_acc0;
        assign w_flg[0] = r_flag0;

        for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_rot
            vmpa_cordic_cell #(.IDX(i)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_x    (w_x[i]),
                .i_y    (w_y[i]),
                .i_acc  (w_acc[i]),
                .i_flag (w_flg[i]),
                .o_x    (w_x[i+1]),
                .o_y    (w_y[i+1]),
                .o_acc  (w_acc[i+1]),
                .o_flag (w_flg[i+1])
            );
        end

        // round half up, clamp, apply the axis cases
        always_comb begin
            w_accr = w_acc[ATAN_STEPS] + ACC_BITS'(HALF);
            w_rnd  = w_accr >>> RSH;
            if (w_flg[ATAN_STEPS].zero) begin
                n_ang = w_flg[ATAN_STEPS].neg ? AW'(LIM) : '0;
            end else if (w_rnd > ACC_BITS'(LIM)) begin
                n_ang = AW'(LIM);
            end else if (w_rnd < -ACC_BITS'(LIM)) begin
                n_ang = -AW'(LIM);
            end else begin
                n_ang = w_rnd[AW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ang <= n_ang;
            end
        end

        if (PAD_AN > 0) begin : g_pad_an
            logic signed [AW-1:0] r_dly [0:PAD_AN-1];
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dly[0] <= r_ang;
                    for (int j = 1; j < PAD_AN; j++) r_dly[j] <= r_dly[j-1];
                end
            end
            assign w_ang[p] = r_dly[PAD_AN-1];
        end else begin : g_nopad_an
            assign w_ang[p] = r_ang;
        end
    end

    // output slot is the last stage of the chain
    assign o_out.valid    = r_vld[D-1];
    assign o_out.length   = w_len;
    assign o_out.angle_xy = w_ang[0];
    assign o_out.angle_xz = w_ang[1];

    // assertions
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input held off without a waiting output item");

    a_chain_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid chain moved during a stall");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.angle_xy <= AW'(LIM)) && (o_out.angle_xy >= -AW'(LIM))
                     && (o_out.angle_xz <= AW'(LIM)) && (o_out.angle_xz >= -AW'(LIM)))
        else $error("angle beyond half circle");
endmodule

FILE: design/vmpa_cordic_cell.sv
// vmpa_cordic_cell: one cordic vectoring rotation, registered
// depends on vmpa_pkg
module vmpa_cordic_cell
    import vmpa_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [DP_BITS-1:0]   i_x,
    input  logic signed [DP_BITS-1:0]   i_y,
    input  logic signed [ACC_BITS-1:0]  i_acc,
    input  t_ang_flag                   i_flag,
    output logic signed [DP_BITS-1:0]   o_x,
    output logic signed [DP_BITS-1:0]   o_y,
    output logic signed [ACC_BITS-1:0]  o_acc,
    output t_ang_flag                   o_flag
);
    logic signed [DP_BITS-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ACC_BITS-1:0] r_acc, n_acc;
    t_ang_flag                  r_flag;

    // rotate toward the positive x axis
    always_comb begin
        if (!i_y[DP_BITS-1]) begin
            n_x   = i_x + (i_y >>> IDX);
            n_y   = i_y - (i_x >>> IDX);
            n_acc = i_acc + atan_step(IDX);
        end else begin
            n_x   = i_x - (i_y >>> IDX);
            n_y   = i_y + (i_x >>> IDX);
            n_acc = i_acc - atan_step(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_flag <= i_flag;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_acc  = r_acc;
    assign o_flag = r_flag;
endmodule

FILE: design/vmpa_sqrt_cell.sv
// vmpa_sqrt_cell: one root digit of the restoring square root, registered
// depends on nothing
module vmpa_sqrt_cell #(
    parameter int SW = 34,
    parameter int PW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_n,
    input  logic [SW+1:0] i_rem,
    input  logic [PW-1:0] i_root,
    output logic [SW-1:0] o_n,
    output logic [SW+1:0] o_rem,
    output logic [PW-1:0] o_root
);
    localparam int RW = SW + 2;

    logic [RW-1:0] w_cat, w_trial, n_rem;
    logic [PW-1:0] n_root;
    logic          w_ge;
    logic [SW-1:0] r_n;
    logic [RW-1:0] r_rem;
    logic [PW-1:0] r_root;

    // bring in the next two bits and try the digit one
    always_comb begin
        w_cat   = {i_rem[RW-3:0], i_n[SW-1 -: 2]};
        w_trial = {{(RW-PW-2){1'b0}}, i_root, 2'b01};
        w_ge    = (w_cat >= w_trial);
        n_rem   = w_ge ? (w_cat - w_trial) : w_cat;
        n_root  = {i_root[PW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= {i_n[SW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
